### rtl/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants
// Field widths and visit mark codes for the depth-first topological sort.
// ----------------------------------------------------------------------------
package dts_pkg;

    // Fixed widths of the interface fields.
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    // Visit marks kept per vertex during a run.
    typedef enum logic [1:0] {
        MARK_WHITE = 2'd0,
        MARK_GRAY  = 2'd1,
        MARK_BLACK = 2'd2
    } t_mark;

    // Item modes.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

endpackage

### rtl/dts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Old data is read on a same-address write; read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/dfs_topological_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topological_sort: depth-first topological sort with cycle detection
// Loads directed edges, then walks the graph and emits vertices in postorder.
// ----------------------------------------------------------------------------
// Usage: an item is accepted when start is high and busy is low. A load item
// (mode 0) appends one edge, with busy high through S_LD1 and S_LD2 after the
// accept. A dropped edge is only flagged and busy stays low. A run item
// (mode 1) walks every vertex and edge: S_SCAN and S_SCAN_W per vertex
// scanned, S_TOP, S_EDGE and, for a target in range, S_CHK per edge, and
// S_TOP and, below the root, S_POP per finished vertex. It then sends beats
// on o_strobe (postorder vertices, one per S_ORD and S_OWAIT pair, or one
// cycle beat), and clears the graph in the cycle of the final beat. Each
// beat is shown for exactly one cycle; the receiver cannot stall. The vertex
// count register is written on the cfg channel, which is ready only while
// the block is idle. Reset (synchronous, active low) empties the graph and
// sets the vertex count to MAX_VERTICES; the memories need no clearing pass
// since list ends and marks carry valid bits.
// ----------------------------------------------------------------------------
module dfs_topological_sort #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [dts_pkg::VERTEX_W-1:0]  i_edge_from,
    input  logic [dts_pkg::VERTEX_W-1:0]  i_edge_to,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dts_pkg::COUNT_W-1:0]   i_cfg_data,
    output logic                          o_strobe,
    output logic [dts_pkg::VERTEX_W-1:0]  o_vertex,
    output logic                          o_cycle_found,
    output logic                          o_last,
    output logic                          o_edges_dropped
);

    import dts_pkg::*;

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int LW = EW + 1;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VERTEX_W + LW;

    typedef enum logic [3:0] {
        S_IDLE, S_LD1, S_LD2, S_SCAN, S_SCAN_W, S_TOP, S_POP, S_EDGE, S_CHK,
        S_ORD, S_OWAIT, S_CYC
    } t_state;

    t_state               r_state;
    logic [COUNT_W-1:0]   r_n;
    logic [CW-1:0]        r_edges;
    logic                 r_drop;
    logic [VERTEX_W-1:0]  r_from;
    logic [VERTEX_W-1:0]  r_to;
    logic                 r_tail_ok;
    logic [MAX_VERTICES-1:0] r_list_ok;
    logic [MAX_VERTICES-1:0] r_mark_ok;
    logic [COUNT_W-1:0]   r_s;
    logic [VERTEX_W-1:0]  r_t;
    logic [VERTEX_W-1:0]  r_top_v;
    logic [LW-1:0]        r_top_next;
    logic [DW-1:0]        r_depth;
    logic [DW-1:0]        r_cnt;
    logic [DW-1:0]        r_k;

    // Memory ports.
    logic                 tgt_we, lnk_we, hd_we, tl_we, mk_we, stk_we, fin_we;
    logic [EW-1:0]        tgt_waddr, lnk_waddr, edge_raddr;
    logic [VERTEX_W-1:0]  tgt_rdata;
    logic [LW-1:0]        lnk_wdata, lnk_rdata, hd_rdata, tl_rdata;
    logic [AW-1:0]        vx_waddr, vx_raddr, mk_waddr, stk_waddr, stk_raddr;
    logic [AW-1:0]        fin_waddr, fin_raddr;
    logic [LW-1:0]        hd_wdata;
    logic [1:0]           mk_wdata, mk_rdata;
    logic [SW-1:0]        stk_wdata, stk_rdata;
    logic [VERTEX_W-1:0]  fin_rdata;

    logic                 accept;
    logic [COUNT_W-1:0]   cfg_n;
    t_mark                mark_rd;
    logic [LW-1:0]        head_rd;
    logic [LW-1:0]        e_new;
    logic [LW-1:0]        nil_link;
    logic [AW-1:0]        vx_idx;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign nil_link    = {1'b1, {EW{1'b0}}};
    assign e_new       = {1'b0, r_edges[EW-1:0]};

    // Clamp the written vertex count into 1 to MAX_VERTICES.
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cfg_n = COUNT_W'(1);
        end else if (i_cfg_data > COUNT_W'(MAX_VERTICES)) begin
            cfg_n = COUNT_W'(MAX_VERTICES);
        end else begin
            cfg_n = i_cfg_data;
        end
    end

    // Vertex whose mark and head were read in the previous cycle.
    assign vx_idx = (r_state == S_CHK) ? r_t[AW-1:0] : r_s[AW-1:0];

    // Marks read as white until written in this run, heads as null until loaded.
    always_comb begin
        mark_rd = r_mark_ok[vx_idx] ? t_mark'(mk_rdata) : MARK_WHITE;
        head_rd = r_list_ok[vx_idx] ? hd_rdata : nil_link;
    end

    // Memory control for each state.
    always_comb begin
        tgt_we    = 1'b0;
        lnk_we    = 1'b0;
        hd_we     = 1'b0;
        tl_we     = 1'b0;
        mk_we     = 1'b0;
        stk_we    = 1'b0;
        fin_we    = 1'b0;
        tgt_waddr = r_edges[EW-1:0];
        lnk_waddr = r_edges[EW-1:0];
        lnk_wdata = nil_link;
        hd_wdata  = e_new;
        vx_waddr  = r_from[AW-1:0];
        vx_raddr  = r_s[AW-1:0];
        mk_waddr  = r_top_v[AW-1:0];
        mk_wdata  = MARK_GRAY;
        stk_waddr = AW'(r_depth - DW'(1));
        stk_wdata = {r_top_v, r_top_next};
        stk_raddr = AW'(r_depth - DW'(2));
        fin_waddr = r_cnt[AW-1:0];
        fin_raddr = r_k[AW-1:0];
        edge_raddr = r_top_next[EW-1:0];
        unique case (r_state)
            S_IDLE: begin
                vx_raddr = i_edge_from[AW-1:0];
            end
            S_LD1: begin
                tgt_we   = 1'b1;
                lnk_we   = 1'b1;
                vx_raddr = r_from[AW-1:0];
            end
            S_LD2: begin
                lnk_we    = r_tail_ok;
                lnk_waddr = tl_rdata[EW-1:0];
                lnk_wdata = e_new;
                hd_we     = !r_tail_ok;
                tl_we     = 1'b1;
            end
            S_SCAN_W: begin
                mk_we    = (mark_rd == MARK_WHITE);
                mk_waddr = r_s[AW-1:0];
            end
            S_TOP: begin
                if (r_top_next[EW]) begin
                    mk_we    = 1'b1;
                    mk_wdata = MARK_BLACK;
                    fin_we   = 1'b1;
                end
            end
            S_EDGE: begin
                vx_raddr = tgt_rdata[AW-1:0];
            end
            S_CHK: begin
                if (mark_rd == MARK_WHITE) begin
                    mk_we    = 1'b1;
                    mk_waddr = r_t[AW-1:0];
                    stk_we   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer for loads, the walk and the result beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_n             <= COUNT_W'(MAX_VERTICES);
            r_edges         <= '0;
            r_drop          <= 1'b0;
            r_list_ok       <= '0;
            r_mark_ok       <= '0;
            o_strobe        <= 1'b0;
            o_vertex        <= '0;
            o_cycle_found   <= 1'b0;
            o_last          <= 1'b0;
            o_edges_dropped <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_n <= cfg_n;
                    end
                    if (accept) begin
                        r_from <= i_edge_from;
                        r_to   <= i_edge_to;
                        if (i_mode == MODE_RUN) begin
                            r_s     <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end else if ({1'b0, i_edge_from} >= r_n
                                || {1'b0, i_edge_to} >= r_n
                                || r_edges >= CW'(MAX_EDGES)) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_state <= S_LD1;
                        end
                    end
                end
                S_LD1: begin
                    r_tail_ok <= r_list_ok[r_from[AW-1:0]];
                    r_state   <= S_LD2;
                end
                S_LD2: begin
                    r_list_ok[r_from[AW-1:0]] <= 1'b1;
                    r_edges <= r_edges + CW'(1);
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_state <= (r_s >= r_n) ? S_ORD : S_SCAN_W;
                    r_k     <= '0;
                end
                S_SCAN_W: begin
                    if (mark_rd == MARK_WHITE) begin
                        r_mark_ok[r_s[AW-1:0]] <= 1'b1;
                        r_top_v    <= r_s[VERTEX_W-1:0];
                        r_top_next <= head_rd;
                        r_depth    <= DW'(1);
                        r_state    <= S_TOP;
                    end else begin
                        r_s     <= r_s + COUNT_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_TOP: begin
                    if (r_top_next[EW]) begin
                        r_cnt   <= r_cnt + DW'(1);
                        r_depth <= r_depth - DW'(1);
                        if (r_depth == DW'(1)) begin
                            r_s     <= r_s + COUNT_W'(1);
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_POP: begin
                    r_top_v    <= stk_rdata[SW-1:LW];
                    r_top_next <= stk_rdata[LW-1:0];
                    r_state    <= S_TOP;
                end
                S_EDGE: begin
                    r_top_next <= lnk_rdata;
                    r_t        <= tgt_rdata;
                    r_state    <= ({1'b0, tgt_rdata} >= r_n) ? S_TOP : S_CHK;
                end
                S_CHK: begin
                    unique case (mark_rd)
                        MARK_GRAY: begin
                            r_state <= S_CYC;
                        end
                        MARK_WHITE: begin
                            r_mark_ok[r_t[AW-1:0]] <= 1'b1;
                            r_top_v    <= r_t;
                            r_top_next <= head_rd;
                            r_depth    <= r_depth + DW'(1);
                            r_state    <= S_TOP;
                        end
                        default: begin
                            r_state <= S_TOP;
                        end
                    endcase
                end
                S_ORD: begin
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    o_strobe        <= 1'b1;
                    o_vertex        <= fin_rdata;
                    o_cycle_found   <= 1'b0;
                    o_last          <= (r_k + DW'(1) == r_cnt);
                    o_edges_dropped <= r_drop;
                    r_k             <= r_k + DW'(1);
                    if (r_k + DW'(1) == r_cnt) begin
                        r_edges   <= '0;
                        r_drop    <= 1'b0;
                        r_list_ok <= '0;
                        r_mark_ok <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_CYC: begin
                    o_strobe        <= 1'b1;
                    o_vertex        <= '0;
                    o_cycle_found   <= 1'b1;
                    o_last          <= 1'b1;
                    o_edges_dropped <= r_drop;
                    r_edges         <= '0;
                    r_drop          <= 1'b0;
                    r_list_ok       <= '0;
                    r_mark_ok       <= '0;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Edge store: target vertex and link to the next edge of the same list.
    dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_EDGES)) u_target (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_waddr), .i_wdata(r_to),
        .i_raddr(edge_raddr), .o_rdata(tgt_rdata)
    );
    dts_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_link (
        .i_clk(i_clk), .i_we(lnk_we), .i_waddr(lnk_waddr), .i_wdata(lnk_wdata),
        .i_raddr(edge_raddr), .o_rdata(lnk_rdata)
    );

    // Per-vertex list ends.
    dts_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(vx_waddr), .i_wdata(hd_wdata),
        .i_raddr(vx_raddr), .o_rdata(hd_rdata)
    );
    dts_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_tail (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(vx_waddr), .i_wdata(e_new),
        .i_raddr(vx_raddr), .o_rdata(tl_rdata)
    );

    // Visit marks.
    dts_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_mark (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_waddr), .i_wdata(mk_wdata),
        .i_raddr(vx_raddr), .o_rdata(mk_rdata)
    );

    // Walk stack below the top frame, which lives in registers.
    dts_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // Postorder buffer.
    dts_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_finish (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(r_top_v),
        .i_raddr(fin_raddr), .o_rdata(fin_rdata)
    );

endmodule
